/* rtl/tiny_accumulator_cpu_execute_core_assert.svh */
// assertion macros shared by the execute core modules
`ifndef TINY_ACCUMULATOR_CPU_EXECUTE_CORE_ASSERT_SVH
`define TINY_ACCUMULATOR_CPU_EXECUTE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked out of reset
`define TACE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tace: implication check failed");

// next-cycle implication, checked out of reset
`define TACE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tace: next-cycle check failed");

`else

`define TACE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define TACE_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/tace_pkg.sv */
// types, constants and microcode table of the tiny accumulator execute core
package tace_pkg;

    // datapath geometry
    localparam int DATA_W      = 8;
    localparam int MEM_IDX_W   = 3;
    localparam int REG_IDX_W   = 2;
    localparam int MEM_DEPTH   = 1 << MEM_IDX_W;
    localparam int REG_COUNT   = 1 << REG_IDX_W;
    localparam int OP_W        = 8;
    localparam int STATUS_W    = 3;
    localparam int UPC_W       = 5;
    localparam int DIV_CNT_W   = $clog2(DATA_W + 1);
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    localparam logic [DIV_CNT_W-1:0] DIV_CNT_INIT = DIV_CNT_W'(DATA_W);
    localparam logic [DIV_CNT_W-1:0] DIV_CNT_LAST = DIV_CNT_W'(1);

    // instruction opcodes
    typedef enum logic [OP_W-1:0] {
        OP_LDR = 8'h00,
        OP_ADD = 8'h01,
        OP_SUB = 8'h02,
        OP_MUL = 8'h03,
        OP_DIV = 8'h04,
        OP_RST = 8'h05,
        OP_HLT = 8'h06,
        OP_LDM = 8'h07,
        OP_STM = 8'h08,
        OP_NOP = 8'h09,
        OP_INC = 8'h0A,
        OP_DEC = 8'h0B,
        OP_MOV = 8'h0C
    } opcode_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_SUB_REFUSED = 3'd1,
        ST_DIV_ZERO    = 3'd2,
        ST_UNKNOWN     = 3'd3,
        ST_HALTED      = 3'd4
    } status_t;

    // value driven onto the write bus
    typedef enum logic [3:0] {
        ALU_NONE,
        ALU_MEM,
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_IMM,
        ALU_REG,
        ALU_INC,
        ALU_DEC,
        ALU_QUO
    } alu_sel_t;

    // jump conditions of a control word
    typedef enum logic [1:0] {
        CND_NEVER,
        CND_NOT_GT,
        CND_DIV_ZERO,
        CND_DIV_BUSY
    } cond_t;

    // microcode addresses; fall-through order matters
    typedef enum logic [UPC_W-1:0] {
        U_IDLE,
        U_LDR,
        U_ADD,
        U_SUB_CHK,
        U_SUB_DO,
        U_SUB_FAIL,
        U_MUL,
        U_DIV_CHK,
        U_DIV_STEP,
        U_DIV_WB,
        U_DIV_ZERO,
        U_RST,
        U_HLT,
        U_LDM,
        U_STM,
        U_NOP,
        U_INC,
        U_DEC,
        U_MOV,
        U_UNK,
        U_HALTED
    } upc_t;

    // one control word
    typedef struct packed {
        alu_sel_t alu_sel;
        logic     reg_we;
        logic     reg_to_dst;
        logic     mem_we;
        status_t  status;
        logic     pc_adv;
        logic     halt_set;
        logic     clear_all;
        logic     div_init;
        logic     div_step;
        cond_t    cond;
        upc_t     target;
        logic     done;
    } uword_t;

    // datapath conditions seen by the sequencer
    typedef struct packed {
        logic gt;
        logic m_zero;
        logic div_busy;
        logic halted;
    } flags_t;

    // decoded instruction, last field in the low bits
    typedef struct packed {
        logic [DATA_W-1:0]    imm;
        logic [REG_IDX_W-1:0] dst;
        logic [REG_IDX_W-1:0] src;
        logic [MEM_IDX_W-1:0] idx;
        logic [OP_W-1:0]      op;
    } instr_t;

    // one result beat, status in the low bits
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] pc;
        status_t           status;
    } result_t;

    localparam int INSTR_W  = $bits(instr_t);
    localparam int RESULT_W = $bits(result_t);

    // entry point of each instruction
    function automatic upc_t dispatch(logic [OP_W-1:0] op, logic halted);
        upc_t u;
        u = U_UNK;
        if (op == OP_RST) begin
            u = U_RST;
        end else if (halted) begin
            u = U_HALTED;
        end else begin
            case (op)
                OP_LDR:  u = U_LDR;
                OP_ADD:  u = U_ADD;
                OP_SUB:  u = U_SUB_CHK;
                OP_MUL:  u = U_MUL;
                OP_DIV:  u = U_DIV_CHK;
                OP_HLT:  u = U_HLT;
                OP_LDM:  u = U_LDM;
                OP_STM:  u = U_STM;
                OP_NOP:  u = U_NOP;
                OP_INC:  u = U_INC;
                OP_DEC:  u = U_DEC;
                OP_MOV:  u = U_MOV;
                default: u = U_UNK;
            endcase
        end
        return u;
    endfunction

    // microcode rom
    function automatic uword_t ucode_word(upc_t a);
        uword_t w;
        w = '0;
        case (a)
            U_LDR: begin
                w.alu_sel = ALU_MEM; w.reg_we = 1'b1; w.pc_adv = 1'b1; w.done = 1'b1;
            end
            U_ADD: begin
                w.alu_sel = ALU_ADD; w.reg_we = 1'b1; w.pc_adv = 1'b1; w.done = 1'b1;
            end
            U_SUB_CHK: begin
                w.cond = CND_NOT_GT; w.target = U_SUB_FAIL;
            end
            U_SUB_DO: begin
                w.alu_sel = ALU_SUB; w.reg_we = 1'b1; w.pc_adv = 1'b1; w.done = 1'b1;
            end
            U_SUB_FAIL: begin
                w.status = ST_SUB_REFUSED; w.pc_adv = 1'b1; w.done = 1'b1;
            end
            U_MUL: begin
                w.alu_sel = ALU_MUL; w.reg_we = 1'b1; w.pc_adv = 1'b1; w.done = 1'b1;
            end
            U_DIV_CHK: begin
                w.div_init = 1'b1; w.cond = CND_DIV_ZERO; w.target = U_DIV_ZERO;
            end
            U_DIV_STEP: begin
                w.div_step = 1'b1; w.cond = CND_DIV_BUSY; w.target = U_DIV_STEP;
            end
            U_DIV_WB: begin
                w.alu_sel = ALU_QUO; w.reg_we = 1'b1; w.pc_adv = 1'b1; w.done = 1'b1;
            end
            U_DIV_ZERO: begin
                w.status = ST_DIV_ZERO; w.pc_adv = 1'b1; w.done = 1'b1;
            end
            U_RST: begin
                w.clear_all = 1'b1; w.done = 1'b1;
            end
            U_HLT: begin
                w.halt_set = 1'b1; w.status = ST_HALTED; w.done = 1'b1;
            end
            U_LDM: begin
                w.alu_sel = ALU_IMM; w.mem_we = 1'b1; w.pc_adv = 1'b1; w.done = 1'b1;
            end
            U_STM: begin
                w.alu_sel = ALU_REG; w.mem_we = 1'b1; w.pc_adv = 1'b1; w.done = 1'b1;
            end
            U_NOP: begin
                w.pc_adv = 1'b1; w.done = 1'b1;
            end
            U_INC: begin
                w.alu_sel = ALU_INC; w.reg_we = 1'b1; w.pc_adv = 1'b1; w.done = 1'b1;
            end
            U_DEC: begin
                w.alu_sel = ALU_DEC; w.reg_we = 1'b1; w.pc_adv = 1'b1; w.done = 1'b1;
            end
            U_MOV: begin
                w.alu_sel = ALU_REG; w.reg_we = 1'b1; w.reg_to_dst = 1'b1;
                w.pc_adv = 1'b1; w.done = 1'b1;
            end
            U_UNK: begin
                w.status = ST_UNKNOWN; w.done = 1'b1;
            end
            U_HALTED: begin
                w.status = ST_HALTED; w.done = 1'b1;
            end
            default: begin
                w = '0;
            end
        endcase
        return w;
    endfunction

endpackage

/* rtl/tiny_accumulator_cpu_execute_core.sv */
// top level of the tiny accumulator execute core: stream ports and result register
// Executes one decoded instruction per input beat and returns one result beat.
// Each beat is taken while the sequencer is idle, then runs a short microprogram:
// most instructions take one step, subtract two, and divide ten (zero check, eight
// restoring quotient steps of one shared subtractor, write-back) or two when the
// divisor is zero. The result register lets the next beat be accepted while the
// previous result still waits on m_axis_tready; a final step that finds the result
// register full holds until it drains. RST clears memory, registers, pc and the halt
// flag in one step and is honored also while halted.
`include "tiny_accumulator_cpu_execute_core_assert.svh"

module tiny_accumulator_cpu_execute_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // mode[7:0], mem_index[10:8], src_reg[12:11], dst_reg[14:13], imm[22:15], zero pad
    input  logic [tace_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // status[2:0], pc[10:3], result_value[18:11], zero pad
    output logic [tace_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready
);

    logic               in_accept;
    logic               out_busy;
    logic               out_load;
    logic               exec;
    logic               idle;
    tace_pkg::instr_t   in_instr;
    tace_pkg::uword_t   uword;
    tace_pkg::flags_t   flags;
    tace_pkg::result_t  res;
    tace_pkg::result_t  m_data_reg;
    logic               m_valid_reg;
    logic               m_valid_next;

    assign in_instr      = tace_pkg::instr_t'(s_axis_tdata[tace_pkg::INSTR_W-1:0]);
    assign s_axis_tready = idle;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_busy      = m_valid_reg && !m_axis_tready;
    assign out_load      = exec && uword.done;

    tace_useq u_useq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .op        (in_instr.op),
        .flags     (flags),
        .out_busy  (out_busy),
        .uword     (uword),
        .exec      (exec),
        .idle      (idle)
    );

    tace_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_load  (in_accept),
        .in_instr (in_instr),
        .uword    (uword),
        .exec     (exec),
        .flags    (flags),
        .res      (res)
    );

    // result valid
    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // result data
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(tace_pkg::OUT_TDATA_W - tace_pkg::RESULT_W){1'b0}}, m_data_reg};

    // a result never overwrites one that is still waiting
    `TACE_ASSERT_IMPLIES(a_no_overwrite, aclk, aresetn, out_load, !out_busy)

endmodule

/* rtl/tace_useq.sv */
// microcode sequencer: step counter, dispatch and conditional jumps
`include "tiny_accumulator_cpu_execute_core_assert.svh"

module tace_useq (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_accept,
    input  logic [tace_pkg::OP_W-1:0]       op,
    input  tace_pkg::flags_t                flags,
    input  logic                            out_busy,
    output tace_pkg::uword_t                uword,
    output logic                            exec,
    output logic                            idle
);

    tace_pkg::upc_t                 upc_reg;
    tace_pkg::upc_t                 upc_next;
    logic [tace_pkg::UPC_W-1:0]     upc_inc;
    logic                           stall;
    logic                           cond_hit;

    // current control word
    always_comb begin
        uword = tace_pkg::ucode_word(upc_reg);
    end

    assign idle    = (upc_reg == tace_pkg::U_IDLE);
    assign stall   = uword.done && out_busy;
    assign exec    = !idle && !stall;
    assign upc_inc = upc_reg + 1'b1;

    // jump condition select
    always_comb begin
        case (uword.cond)
            tace_pkg::CND_NEVER:    cond_hit = 1'b0;
            tace_pkg::CND_NOT_GT:   cond_hit = !flags.gt;
            tace_pkg::CND_DIV_ZERO: cond_hit = flags.m_zero;
            tace_pkg::CND_DIV_BUSY: cond_hit = flags.div_busy;
            default:                cond_hit = 1'b0;
        endcase
    end

    // next step
    always_comb begin
        upc_next = upc_reg;
        if (idle) begin
            if (in_accept) begin
                upc_next = tace_pkg::dispatch(op, flags.halted);
            end
        end else if (exec) begin
            if (cond_hit) begin
                upc_next = uword.target;
            end else if (uword.done) begin
                upc_next = tace_pkg::U_IDLE;
            end else begin
                upc_next = tace_pkg::upc_t'(upc_inc);
            end
        end
    end

    // step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= tace_pkg::U_IDLE;
        end else begin
            upc_reg <= upc_next;
        end
    end

    // a final step waiting on the output holds its place
    `TACE_ASSERT_NEXT(a_stall_holds, aclk, aresetn, (!idle && stall), $stable(upc_reg))
    // an accepted beat always starts a program
    `TACE_ASSERT_NEXT(a_accept_starts, aclk, aresetn, in_accept, (upc_reg != tace_pkg::U_IDLE))
    // nonzero divisor enters the quotient loop
    `TACE_ASSERT_NEXT(a_div_enters_loop, aclk, aresetn,
        ((upc_reg == tace_pkg::U_DIV_CHK) && !flags.m_zero),
        (upc_reg == tace_pkg::U_DIV_STEP))

endmodule

/* rtl/tace_dpath.sv */
// datapath: data memory, register file, alu, restoring divider, pc and halt flag
`include "tiny_accumulator_cpu_execute_core_assert.svh"

module tace_dpath (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_load,
    input  tace_pkg::instr_t    in_instr,
    input  tace_pkg::uword_t    uword,
    input  logic                exec,
    output tace_pkg::flags_t    flags,
    output tace_pkg::result_t   res
);

    localparam int DW = tace_pkg::DATA_W;

    logic [DW-1:0]                  mem_reg [tace_pkg::MEM_DEPTH];
    logic [DW-1:0]                  regs_reg [tace_pkg::REG_COUNT];
    logic [DW-1:0]                  pc_reg;
    logic                           halted_reg;
    tace_pkg::instr_t               instr_reg;
    logic [DW-1:0]                  quo_reg;
    logic [DW-1:0]                  rem_reg;
    logic [tace_pkg::DIV_CNT_W-1:0] cnt_reg;

    logic [DW-1:0]                  m_val;
    logic [DW-1:0]                  r_val;
    logic [2*DW-1:0]                prod;
    logic [DW:0]                    partial;
    logic [DW:0]                    diff;
    logic                           no_borrow;
    logic [DW-1:0]                  alu_out;
    logic [DW-1:0]                  pc_after;
    logic [tace_pkg::REG_IDX_W-1:0] reg_wr_idx;

    // operand reads
    assign m_val = mem_reg[instr_reg.idx];
    assign r_val = regs_reg[instr_reg.src];
    assign prod  = r_val * m_val;

    // one restoring divide step
    assign partial   = {rem_reg, quo_reg[DW-1]};
    assign diff      = partial - {1'b0, m_val};
    assign no_borrow = (partial >= {1'b0, m_val});

    // write bus select
    always_comb begin
        case (uword.alu_sel)
            tace_pkg::ALU_NONE: alu_out = '0;
            tace_pkg::ALU_MEM:  alu_out = m_val;
            tace_pkg::ALU_ADD:  alu_out = r_val + m_val;
            tace_pkg::ALU_SUB:  alu_out = r_val - m_val;
            tace_pkg::ALU_MUL:  alu_out = prod[DW-1:0];
            tace_pkg::ALU_IMM:  alu_out = instr_reg.imm;
            tace_pkg::ALU_REG:  alu_out = r_val;
            tace_pkg::ALU_INC:  alu_out = r_val + 1'b1;
            tace_pkg::ALU_DEC:  alu_out = r_val - 1'b1;
            tace_pkg::ALU_QUO:  alu_out = quo_reg;
            default:            alu_out = '0;
        endcase
    end

    assign reg_wr_idx = uword.reg_to_dst ? instr_reg.dst : instr_reg.src;

    // program counter after this step
    always_comb begin
        if (uword.clear_all) begin
            pc_after = '0;
        end else if (uword.pc_adv) begin
            pc_after = pc_reg + 1'b1;
        end else begin
            pc_after = pc_reg;
        end
    end

    // result of the final step
    assign res.status = uword.status;
    assign res.pc     = pc_after;
    assign res.value  = (uword.reg_we || uword.mem_we) ? alu_out : '0;

    // conditions for the sequencer
    assign flags.gt       = (r_val > m_val);
    assign flags.m_zero   = (m_val == '0);
    assign flags.div_busy = (cnt_reg != tace_pkg::DIV_CNT_LAST);
    assign flags.halted   = halted_reg;

    // instruction latch
    always_ff @(posedge aclk) begin
        if (in_load) begin
            instr_reg <= in_instr;
        end
    end

    // divider state
    always_ff @(posedge aclk) begin
        if (exec && uword.div_init) begin
            quo_reg <= r_val;
            rem_reg <= '0;
            cnt_reg <= tace_pkg::DIV_CNT_INIT;
        end else if (exec && uword.div_step) begin
            quo_reg <= {quo_reg[DW-2:0], no_borrow};
            rem_reg <= no_borrow ? diff[DW-1:0] : partial[DW-1:0];
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn || (exec && uword.clear_all)) begin
            for (int i = 0; i < tace_pkg::MEM_DEPTH; i++) begin
                mem_reg[i] <= '0;
            end
            for (int j = 0; j < tace_pkg::REG_COUNT; j++) begin
                regs_reg[j] <= '0;
            end
            pc_reg     <= '0;
            halted_reg <= 1'b0;
        end else if (exec) begin
            if (uword.mem_we) begin
                mem_reg[instr_reg.idx] <= alu_out;
            end
            if (uword.reg_we) begin
                regs_reg[reg_wr_idx] <= alu_out;
            end
            if (uword.halt_set) begin
                halted_reg <= 1'b1;
            end
            pc_reg <= pc_after;
        end
    end

    // halt is entered only through the halt step
    `TACE_ASSERT_IMPLIES(a_halt_source, aclk, aresetn, $rose(halted_reg),
        $past(exec && uword.halt_set))
    // a halted machine keeps its pc until cleared
    `TACE_ASSERT_NEXT(a_halted_pc_frozen, aclk, aresetn,
        (halted_reg && !(exec && uword.clear_all)), $stable(pc_reg))

endmodule
